### rtl/core/mtab_pkg.sv
// ----------------------------------------------------------------------------
// mtab_pkg
// Shared types and constants for the compacting membership table.
// ----------------------------------------------------------------------------
package mtab_pkg;

    localparam int MAX_MEMBERS = 16;
    localparam int KEY_BYTES   = 8;

    localparam int SLOT_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int CNT_W  = $clog2(MAX_MEMBERS + 1);

    localparam logic [63:0] KEY_MASK = (KEY_BYTES >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                       ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 104;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_FIND   = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EXISTS    = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    typedef struct packed {
        logic ld;
        logic cmp;
        logic upd;
    } t_dp_cmd;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] addr;
        logic [15:0] port;
        logic        founder;
        logic [39:0] joined;
    } t_entry;

endpackage

### rtl/core/member_table_insert_remove_lookup_top.sv
// ----------------------------------------------------------------------------
// member_table_insert_remove_lookup_top
// Compacting membership table with add, remove and find requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel, one transfer per request; each
//   request gives exactly one result transfer on the m_axis channel.
//   Add appends a member at the fill point, refused when the table is full
//   or the key is present. Remove closes the gap by shifting later entries
//   down one slot, all at commit. Find returns the stored fields.
// Sequencing:
//   A request transfer is followed by a compare state for the parallel
//   key compare over all slots, then a commit state for the table commit
//   and result load. A new request may be taken in the commit state.
// Stall:
//   The result sits in an output register until taken. One more request may
//   be accepted and compared meanwhile; it then waits at commit until the
//   output register frees.
// Reset:
//   Synchronous active-low reset empties the table (member count zero) and
//   drops any pending result. No clearing pass is needed.
// ----------------------------------------------------------------------------
module member_table_insert_remove_lookup_top
    import mtab_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // req_type[1:0], member_key[65:2], ipv4_addr[97:66], port_num[113:98],
    // founder_flag[114], now_ms[154:115], zero[159:155]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // status[1:0], hit_index[5:2], found_addr[37:6], found_port[53:38],
    // found_founder[54], found_joined[94:55], count_after[99:95], zero[103:100]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    t_dp_cmd cmd;

    mtab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    mtab_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req_data (i_s_axis_tdata),
        .o_res_data (o_m_axis_tdata)
    );

endmodule

### rtl/core/mtab_ctrl.sv
// ----------------------------------------------------------------------------
// mtab_ctrl
// Request sequencer: latch, compare, commit, and output handshake.
// ----------------------------------------------------------------------------
module mtab_ctrl
    import mtab_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   can_upd;

    assign can_upd = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (can_upd) begin
                    n_state = i_in_valid ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
            end
            S_UPD: begin
                // next request may enter in the same cycle the result is committed
                o_in_ready = can_upd;
                o_cmd.upd  = can_upd;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.ld = i_in_valid && o_in_ready;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.upd) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/mtab_dp.sv
// ----------------------------------------------------------------------------
// mtab_dp
// Member table, parallel key compare, compaction shift and result register.
// ----------------------------------------------------------------------------
module mtab_dp
    import mtab_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [IN_TDATA_W-1:0]  i_req_data,
    output logic [OUT_TDATA_W-1:0] o_res_data
);

    t_entry              r_tab [MAX_MEMBERS];
    logic [CNT_W-1:0]    r_count;

    logic [1:0]          r_req_type;
    t_entry              r_req;

    logic                r_hit;
    logic [SLOT_W-1:0]   r_slot;

    logic [MAX_MEMBERS-1:0] match;
    logic [SLOT_W-1:0]      match_slot;

    logic [OUT_TDATA_W-1:0] r_res;
    logic [OUT_TDATA_W-1:0] n_res;
    logic [CNT_W-1:0]       n_count;
    logic                   do_add;
    logic                   do_remove;
    logic                   full;
    logic [SLOT_W+3:0]      slot_ext;
    logic [CNT_W+3:0]       cnt_ext;
    logic [CNT_W+4:0]       cnt_after_ext;
    logic [1:0]             st;
    logic [3:0]             idx;
    t_entry                 sel;
    logic                   fnd;

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_req_type     <= i_req_data[1:0];
            r_req.key      <= i_req_data[65:2] & KEY_MASK;
            r_req.addr     <= i_req_data[97:66];
            r_req.port     <= i_req_data[113:98];
            r_req.founder  <= i_req_data[114];
            r_req.joined   <= i_req_data[154:115];
        end
    end

    // parallel compare over in-use slots
    always_comb begin
        for (int i = 0; i < MAX_MEMBERS; i++) begin
            match[i] = (CNT_W'(i) < r_count) && (r_tab[i].key == r_req.key);
        end
        match_slot = '0;
        for (int i = MAX_MEMBERS - 1; i >= 0; i--) begin
            if (match[i]) begin
                match_slot = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_hit  <= |match;
            r_slot <= match_slot;
        end
    end

    // commit decision
    always_comb begin
        full      = r_count >= CNT_W'(MAX_MEMBERS);
        do_add    = 1'b0;
        do_remove = 1'b0;
        fnd       = 1'b0;
        n_count   = r_count;
        st        = ST_NOT_FOUND;
        slot_ext  = {4'b0, r_slot};
        cnt_ext   = {4'b0, r_count};
        idx       = 4'd0;
        case (r_req_type)
            REQ_ADD: begin
                if (full) begin
                    st = ST_FULL;
                end else if (r_hit) begin
                    st  = ST_EXISTS;
                    idx = slot_ext[3:0];
                end else begin
                    st      = ST_OK;
                    idx     = cnt_ext[3:0];
                    do_add  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_REMOVE: begin
                if (r_hit) begin
                    st        = ST_OK;
                    idx       = slot_ext[3:0];
                    do_remove = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            REQ_FIND: begin
                if (r_hit) begin
                    st  = ST_OK;
                    idx = slot_ext[3:0];
                    fnd = 1'b1;
                end
            end
            default: begin
                st = ST_NOT_FOUND;
            end
        endcase
        cnt_after_ext = {5'b0, n_count};
        sel = r_tab[r_slot];
        n_res = '0;
        n_res[1:0]   = st;
        n_res[5:2]   = idx;
        if (fnd) begin
            n_res[37:6]  = sel.addr;
            n_res[53:38] = sel.port;
            n_res[54]    = sel.founder;
            n_res[94:55] = sel.joined;
        end
        n_res[99:95] = cnt_after_ext[4:0];
    end

    // table update: append at the fill point, or close the gap on remove
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            for (int i = 0; i < MAX_MEMBERS - 1; i++) begin
                if (do_remove && (SLOT_W'(i) >= r_slot) && (CNT_W'(i + 1) < r_count)) begin
                    r_tab[i] <= r_tab[i + 1];
                end
            end
            if (do_add) begin
                r_tab[r_count[SLOT_W-1:0]] <= r_req;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.upd) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_res <= n_res;
        end
    end

    assign o_res_data = r_res;

endmodule

### rtl/core/mtab_chk.sv
// ----------------------------------------------------------------------------
// mtab_chk
// Port-level checks for the membership table, bound to the top level.
// ----------------------------------------------------------------------------
module mtab_chk
    import mtab_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // a request transfer is followed by its compare cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request taken during compare cycle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

    // refusal for a full table reports a full count and no slot
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[1:0] == ST_FULL)) |->
        ((o_m_axis_tdata[99:95] == 5'(MAX_MEMBERS)) && (o_m_axis_tdata[5:2] == 4'd0)))
        else $error("full status with wrong count or slot");

    // found fields are zero unless the request succeeded
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[1:0] != ST_OK)) |-> (o_m_axis_tdata[94:6] == '0))
        else $error("found fields set on failed request");

endmodule

bind member_table_insert_remove_lookup_top mtab_chk u_mtab_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
